// ===== rtl/qhsw_pkg.sv =====
package qhsw_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SIGNED_MODE    = 3'd0,
        CFG_IN_SCALE       = 3'd1,
        CFG_IN_ZERO_POINT  = 3'd2,
        CFG_OUT_INV_SCALE  = 3'd3,
        CFG_OUT_ZERO_POINT = 3'd4
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] IN_SCALE_RST      = 32'h0100_0000;
    localparam logic [31:0] OUT_INV_SCALE_RST = 32'h0001_0000;

    // Pipeline depth; the last stage is the output register.
    localparam int NUM_ST = 9;

    // 3.0 in Q.24 and its negative, at the width of the dequantized value.
    localparam logic signed [42:0] X_THREE     = 43'sd50331648;
    localparam logic signed [42:0] X_NEG_THREE = -43'sd50331648;
    localparam logic signed [27:0] X_THREE_28  = 28'sd50331648;

    // Offset that makes the Q.23 partial quotient nonnegative (3 * 2^25).
    localparam logic [29:0] DIV_OFFSET = 30'd100663296;
    // ceil(2^29 / 3): floor(u / 3) = (u * DIV_RECIP) >> 29 for u < 2^29.
    localparam logic [27:0] DIV_RECIP  = 28'd178956971;
    localparam int          DIV_SHIFT  = 29;
    localparam logic signed [42:0] QUOT_BIAS = 43'sd33554432;

    typedef struct packed {
        logic [7:0] sample_in;
        logic       last_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] sample_out;
        logic       last_out;
    } t_out_word;

endpackage

// ===== rtl/quantized_hardswish_8bit_unit.sv =====
// Quantized int8 hardswish with fixed-point dequantize and requantize.
// Throughput: one word per cycle unless stalled; every stage holds its word while stalled.
// The input multiplier, the x*(x+3) multiplier and the divide-by-3 reciprocal
// multiplier each own a stage; the two requantize partial products share one.
// Reset (synchronous, active low) empties the pipeline and restores config.
module quantized_hardswish_8bit_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  qhsw_pkg::t_in_word            i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output qhsw_pkg::t_out_word           o_data,
    input  logic                          i_cfg_we,
    input  logic [qhsw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qhsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import qhsw_pkg::*;

    // Configuration.
    logic        r_signed_mode;
    logic [31:0] r_in_scale;
    logic [8:0]  r_in_zp;
    logic [31:0] r_out_inv_scale;
    logic [8:0]  r_out_zp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode   <= 1'b0;
            r_in_scale      <= IN_SCALE_RST;
            r_in_zp         <= 9'd0;
            r_out_inv_scale <= OUT_INV_SCALE_RST;
            r_out_zp        <= 9'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIGNED_MODE:    r_signed_mode   <= i_cfg_data[0];
                CFG_IN_SCALE:       r_in_scale      <= i_cfg_data;
                CFG_IN_ZERO_POINT:  r_in_zp         <= i_cfg_data[8:0];
                CFG_OUT_INV_SCALE:  r_out_inv_scale <= i_cfg_data;
                CFG_OUT_ZERO_POINT: r_out_zp        <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: a stage moves when it is empty or the next one moves.
    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST-1:0] r_last;
    logic [NUM_ST-1:0] en;

    always_comb begin
        en[NUM_ST-1] = !r_vld[NUM_ST-1] || !i_stall;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NUM_ST; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) r_last[0] <= i_data.last_in;
        for (int k = 1; k < NUM_ST; k++) begin
            if (en[k]) r_last[k] <= r_last[k-1];
        end
    end

    // Stage 1: offset by the input zero point.
    logic        [8:0] n_q;
    logic signed [9:0] n_d;
    logic signed [9:0] r_d;

    assign n_q = r_signed_mode ? {i_data.sample_in[7], i_data.sample_in}
                               : {1'b0, i_data.sample_in};
    assign n_d = $signed({n_q[8], n_q}) - $signed({r_in_zp[8], r_in_zp});

    always_ff @(posedge i_clk) begin
        if (en[0]) r_d <= n_d;
    end

    // Stage 2: dequantize, x = d * in_scale in Q.24.
    logic signed [32:0] n_scale;
    logic signed [42:0] n_x;
    logic signed [42:0] r_x2;

    assign n_scale = $signed({1'b0, r_in_scale});
    assign n_x     = r_d * n_scale;

    always_ff @(posedge i_clk) begin
        if (en[1]) r_x2 <= n_x;
    end

    // Stage 3: region test and x * (x + 3) for the curved part (Q.48).
    logic signed [26:0] n_xm;
    logic signed [27:0] n_xp;
    logic signed [54:0] n_n;
    logic signed [54:0] r_n;
    logic signed [42:0] r_x3;
    logic               r_ge3_3, r_le3_3;

    assign n_xm = r_x2[26:0];
    assign n_xp = $signed({n_xm[26], n_xm}) + X_THREE_28;
    assign n_n  = n_xm * n_xp;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_n     <= n_n;
            r_x3    <= r_x2;
            r_ge3_3 <= (r_x2 >= X_THREE);
            r_le3_3 <= (r_x2 <= X_NEG_THREE);
        end
    end

    // Stage 4: floor(n / (6 * 2^24)) as floor(floor(n / 2^25) / 3), the
    // division by 3 done with a reciprocal on an offset nonnegative value.
    logic [29:0] n_u30;
    logic [27:0] n_u;
    logic [55:0] n_prod;
    logic [55:0] r_prod;
    logic signed [42:0] r_x4;
    logic               r_ge3_4, r_le3_4;

    assign n_u30  = r_n[54:25] + DIV_OFFSET;
    assign n_u    = n_u30[27:0];
    assign n_prod = n_u * DIV_RECIP;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_prod  <= n_prod;
            r_x4    <= r_x3;
            r_ge3_4 <= r_ge3_3;
            r_le3_4 <= r_le3_3;
        end
    end

    // Stage 5: select the hardswish value and split it into sign and magnitude.
    logic        [26:0] n_quot;
    logic signed [42:0] n_hmid;
    logic signed [42:0] n_h;
    logic signed [42:0] n_hneg;
    logic        [41:0] r_m;
    logic               r_neg5;

    assign n_quot = r_prod[DIV_SHIFT +: 27];
    assign n_hmid = $signed({16'd0, n_quot}) - QUOT_BIAS;
    assign n_h    = r_ge3_4 ? r_x4 : (r_le3_4 ? 43'sd0 : n_hmid);
    assign n_hneg = -n_h;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_neg5 <= n_h[42];
            r_m    <= n_h[42] ? n_hneg[41:0] : n_h[41:0];
        end
    end

    // Stage 6: partial products of |h| * out_inv_scale.
    logic [41:0] r_phi;
    logic [63:0] r_plo;
    logic        r_neg6;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_phi  <= r_m[41:32] * r_out_inv_scale;
            r_plo  <= r_m[31:0] * r_out_inv_scale;
            r_neg6 <= r_neg5;
        end
    end

    // Stage 7: full Q.40 magnitude; anything at or above 1024 saturates.
    logic [73:0] n_mag;
    logic [49:0] r_mag;
    logic        r_sat7, r_neg7;

    assign n_mag = {r_phi, 32'd0} + {10'd0, r_plo};

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_mag  <= n_mag[49:0];
            r_sat7 <= |n_mag[73:50];
            r_neg7 <= r_neg6;
        end
    end

    // Stage 8: apply the sign and add the output zero point.
    logic signed [51:0] n_smag;
    logic signed [51:0] n_v;
    logic signed [51:0] r_v;
    logic               r_sat8, r_neg8;

    assign n_smag = r_neg7 ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
    assign n_v    = n_smag + $signed({{3{r_out_zp[8]}}, r_out_zp, 40'd0});

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_v    <= n_v;
            r_sat8 <= r_sat7;
            r_neg8 <= r_neg7;
        end
    end

    // Stage 9: round half to even, then clamp. Rounding before the clamp
    // gives the same answer because the bounds are whole numbers.
    logic signed [11:0] n_ip;
    logic               n_inc;
    logic signed [12:0] n_r;
    logic signed [12:0] n_lo, n_hi;
    logic signed [12:0] n_res;
    logic        [7:0]  r_sample_out;

    assign n_ip  = r_v[51:40];
    assign n_inc = r_v[39] && ((|r_v[38:0]) || n_ip[0]);
    assign n_r   = $signed({n_ip[11], n_ip}) + $signed({12'd0, n_inc});
    assign n_lo  = r_signed_mode ? -13'sd128 : 13'sd0;
    assign n_hi  = r_signed_mode ? 13'sd127 : 13'sd255;

    always_comb begin
        if (r_sat8) begin
            n_res = r_neg8 ? n_lo : n_hi;
        end else if (n_r < n_lo) begin
            n_res = n_lo;
        end else if (n_r > n_hi) begin
            n_res = n_hi;
        end else begin
            n_res = n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) r_sample_out <= n_res[7:0];
    end

    assign o_valid         = r_vld[NUM_ST-1];
    assign o_data.sample_out = r_sample_out;
    assign o_data.last_out   = r_last[NUM_ST-1];

    // The input side only stalls when every stage is full and the output waits.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled while the pipeline has room");

    // The two saturated regions of hardswish never overlap.
    a_region_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> !(r_ge3_3 && r_le3_3))
        else $error("hardswish region flags both set");

    // A taken output word with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_vld[NUM_ST-2]) |=> !o_valid)
        else $error("output word repeated");

endmodule

// ===== tb/sv/hswish_check_pkg.sv =====
`timescale 1ns / 100ps

package hswish_check_pkg;
    import qhsw_pkg::*;

    localparam longint          ONE_Q24    = 64'sd1 <<< 24;
    localparam longint          THREE_Q24  = 3 * ONE_Q24;
    localparam longint          ONE_Q40    = 64'sd1 <<< 40;
    localparam longint unsigned FRAC_MASK  = (64'd1 << 40) - 64'd1;
    localparam longint unsigned HALF_Q40   = 64'd1 << 39;
    localparam longint unsigned MAG_LIMIT  = 64'd1 << 50;
    localparam longint unsigned HIGH_LIMIT = 64'd1 << 18;

    class hswish_scoreboard;
        bit          cfg_signed;
        logic [31:0] cfg_in_scale;
        int          cfg_in_zp;
        logic [31:0] cfg_out_inv;
        int          cfg_out_zp;
        t_out_word   expected_q[$];
        int          error_cnt;

        function new();
            cfg_signed   = 1'b0;
            cfg_in_scale = IN_SCALE_RST;
            cfg_in_zp    = 0;
            cfg_out_inv  = OUT_INV_SCALE_RST;
            cfg_out_zp   = 0;
            error_cnt    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SIGNED_MODE:    cfg_signed   = val[0];
                CFG_IN_SCALE:       cfg_in_scale = val;
                CFG_IN_ZERO_POINT:  cfg_in_zp    = int'($signed(val[8:0]));
                CFG_OUT_INV_SCALE:  cfg_out_inv  = val;
                CFG_OUT_ZERO_POINT: cfg_out_zp   = int'($signed(val[8:0]));
                default: ;
            endcase
        endfunction

        // Hardswish on a Q.24 value; the middle segment rounds toward minus infinity.
        function longint hswish_q24(longint x);
            longint prod;
            if (x >= THREE_Q24)
                return x;
            if (x <= -THREE_Q24)
                return 0;
            prod = x * (x + THREE_Q24);
            // The offset keeps the dividend positive so the division is a floor.
            return (prod + 6 * (64'sd1 <<< 50)) / (6 * ONE_Q24) - (64'sd1 <<< 26);
        endfunction

        function logic [7:0] requantize(longint h, longint lo, longint hi);
            bit              neg;
            longint unsigned mag_in, p_hi, p_lo, mag, u, ip, frac;
            longint          v;
            neg    = h < 0;
            mag_in = neg ? -h : h;
            p_hi   = (mag_in >> 32) * {32'd0, cfg_out_inv};
            p_lo   = (mag_in & 64'hFFFF_FFFF) * {32'd0, cfg_out_inv};
            if (p_hi >= HIGH_LIMIT || p_lo >= MAG_LIMIT)
                return neg ? lo[7:0] : hi[7:0];
            mag = (p_hi << 32) + p_lo;
            if (mag >= MAG_LIMIT)
                return neg ? lo[7:0] : hi[7:0];
            v = longint'(mag);
            if (neg)
                v = -v;
            v = v + longint'(cfg_out_zp) * ONE_Q40;
            if (v < lo * ONE_Q40)
                v = lo * ONE_Q40;
            if (v > hi * ONE_Q40)
                v = hi * ONE_Q40;
            u    = v + 256 * ONE_Q40;
            ip   = u >> 40;
            frac = u & FRAC_MASK;
            if (frac > HALF_Q40 || (frac == HALF_Q40 && ip[0]))
                ip = ip + 1;
            return ip[7:0];
        endfunction

        function void note_input(t_in_word w);
            longint    q, lo, hi, x;
            t_out_word r;
            if (cfg_signed) begin
                q  = $signed(w.sample_in);
                lo = -128;
                hi = 127;
            end else begin
                q  = w.sample_in;
                lo = 0;
                hi = 255;
            end
            x = (q - cfg_in_zp) * longint'({32'd0, cfg_in_scale});
            r.sample_out = requantize(hswish_q24(x), lo, hi);
            r.last_out   = w.last_in;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            error_cnt++;
        endtask

        task check_output(t_out_word got);
            t_out_word exp_w;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("output word %h with nothing pending", got));
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.sample_out !== exp_w.sample_out)
                report_mismatch($sformatf("sample_out %h, predicted %h",
                                          got.sample_out, exp_w.sample_out));
            if (got.last_out !== exp_w.last_out)
                report_mismatch($sformatf("last_out %b, predicted %b",
                                          got.last_out, exp_w.last_out));
        endtask
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import qhsw_pkg::*;
    import hswish_check_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_WORDS = 123;
    localparam int HOLD_PHASE  = 4;
    localparam int PAUSE_PHASE = 6;
    localparam int LONG_HOLD   = 64;
    localparam int STALL_LIMIT = 1000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_word              i_data;
    logic                  o_valid;
    logic                  i_stall;
    t_out_word             o_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hswish_scoreboard sb;
    bit               send_idle;
    bit               recv_idle;
    int               hold_requests;
    int               idle_cycles;

    quantized_hardswish_8bit_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_input(i_data);
            if (o_valid && !i_stall)
                sb.check_output(o_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output side: random stall bursts, plus a long hold-off when the sequence asks.
    initial begin : out_stall_gen
        int served;
        served  = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != served) begin
                served++;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (recv_idle && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic [7:0] sample, input logic last);
        @(negedge i_clk);
        if (send_idle && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data.sample_in <= sample;
        i_data.last_in   <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Stop offering words and wait until every predicted word has come out.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(input bit mode, input logic [31:0] in_sc, input int in_zp,
                              input logic [31:0] out_inv, input int out_zp);
        write_reg(CFG_SIGNED_MODE, {31'd0, mode});
        write_reg(CFG_IN_SCALE, in_sc);
        write_reg(CFG_IN_ZERO_POINT, 32'(in_zp));
        write_reg(CFG_OUT_INV_SCALE, out_inv);
        write_reg(CFG_OUT_ZERO_POINT, 32'(out_zp));
        // An index past the last register must leave everything unchanged.
        if ($urandom_range(0, 2) == 0)
            write_reg(3'(CFG_OUT_ZERO_POINT + $urandom_range(1, 3)), $urandom);
    endtask

    task automatic run_directed();
        logic [7:0] plain_vals[7]  = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd127, 8'd128, 8'd255};
        logic [7:0] tie_vals[8]    = '{8'h80, 8'h7F, 8'hFF, 8'hFE, 8'hFD, 8'd3, 8'd5, 8'd7};
        logic [7:0] zero_vals[3]   = '{8'h00, 8'hFF, 8'hAA};
        logic [7:0] huge_vals[4]   = '{8'h80, 8'h7F, 8'h00, 8'h01};
        send_idle = 1'b0;
        recv_idle = 1'b0;
        // Reset settings: unit scales, unsigned samples.
        foreach (plain_vals[i]) send_word(plain_vals[i], i[0]);
        drain();
        // An output scale of one half puts odd inputs above three exactly halfway.
        set_config(1'b1, 32'h0100_0000, 0, 32'h0000_8000, 0);
        foreach (tie_vals[i]) send_word(tie_vals[i], !i[0]);
        drain();
        // Zero scales, with an input zero point outside the sample range.
        set_config(1'b0, 32'd0, -256, 32'd0, 255);
        foreach (zero_vals[i]) send_word(zero_vals[i], i[0]);
        drain();
        // Largest scales: products far beyond the range saturate.
        set_config(1'b1, 32'hFFFF_FFFF, 255, 32'hFFFF_FFFF, -128);
        foreach (huge_vals[i]) send_word(huge_vals[i], i[0]);
        drain();
    endtask

    task automatic run_phase(input int k);
        bit          mode;
        logic [31:0] in_sc, out_inv;
        int          in_zp, out_zp;
        mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       in_sc = 32'hFFFF_FFFF;
            1:       in_sc = 32'd1;
            2:       in_sc = $urandom;
            default: in_sc = $urandom_range(32'h0001_0000, 32'h0040_0000);
        endcase
        case ($urandom_range(0, 7))
            0:       out_inv = 32'hFFFF_FFFF;
            1:       out_inv = $urandom_range(1, 32'h0000_FFFF);
            2:       out_inv = $urandom;
            default: out_inv = $urandom_range(32'h0004_0000, 32'h0100_0000);
        endcase
        in_zp  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) - 256
                                             : $urandom_range(0, 383) - 128;
        out_zp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) - 256
                                             : $urandom_range(0, 383) - 128;
        if (k == 0) begin
            in_sc   = 32'hFFFF_FFFF;
            out_inv = 32'hFFFF_FFFF;
            in_zp   = -128;
            out_zp  = 255;
        end else if (k == 1) begin
            in_sc   = 32'd1;
            out_inv = 32'd1;
            in_zp   = 255;
            out_zp  = -128;
        end
        set_config(mode, in_sc, in_zp, out_inv, out_zp);

        send_idle = (k % 3 != 1) && (k != NUM_PHASES - 1);
        recv_idle = (k % 4 != 2) && (k != NUM_PHASES - 1);
        if (k == HOLD_PHASE) begin
            // Keep offering words while the output is held, so the pipeline backs up.
            send_idle = 1'b0;
            hold_requests++;
        end
        for (int i = 0; i < PHASE_WORDS; i++) begin
            if (k == PAUSE_PHASE && i == PHASE_WORDS / 2)
                drain();
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        drain();
    endtask

    initial begin : main_seq
        sb            = new();
        send_idle     = 1'b0;
        recv_idle     = 1'b0;
        hold_requests = 0;
        idle_cycles   = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int k = 0; k < NUM_PHASES; k++)
            run_phase(k);

        // Any stray word after the last one counts as unexpected.
        repeat (2 * NUM_ST) @(posedge i_clk);
        if (sb.error_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== quantized_hardswish_8bit_unit.f =====
rtl/qhsw_pkg.sv
rtl/quantized_hardswish_8bit_unit.sv
tb/sv/hswish_check_pkg.sv
tb/sv/testbench.sv
